// File: sv/wga_pkg.sv
// ----------------------------------------------------------------------------
// wga_pkg: shared types, codes and double-precision helpers
// Row and lane-control types, register and mode codes, and the round/pack
// step shared by the floating-point multiply and add units.
// ----------------------------------------------------------------------------
package wga_pkg;

   localparam int DBL_W           = 64;
   localparam int NUM_X           = 8;   // regressor columns carried by one item
   localparam int XIDX_W          = 3;
   localparam int MAX_COLUMNS_DEF = 8;
   localparam int CSR_ADDR_W      = 4;
   localparam int CSR_DATA_W      = 32;
   localparam int EXP_W           = 13;  // signed working exponent

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_WEIGHT_MODE     = 2'd0;
   localparam logic [1:0] REG_VECTOR_WEIGHTED = 2'd1;
   localparam logic [1:0] REG_ACTIVE_COLUMNS  = 2'd2;

   // row factor codes
   localparam logic [2:0] MODE_ONE  = 3'd0;
   localparam logic [2:0] MODE_W    = 3'd1;
   localparam logic [2:0] MODE_W2   = 3'd2;
   localparam logic [2:0] MODE_E2W2 = 3'd3;
   localparam logic [2:0] MODE_E2W  = 3'd4;

   localparam logic [3:0] ACTIVE_COLUMNS_RESET = 4'd8;

   localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
   localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;

   typedef struct packed {
      logic [NUM_X-1:0][DBL_W-1:0] x;
      logic [DBL_W-1:0]            y;
      logic [DBL_W-1:0]            w;
      logic [DBL_W-1:0]            e;
   } row_type;

   typedef struct packed {
      logic       start;
      logic       clear;
      logic [2:0] mode;
      logic       vec_weighted;
      logic [3:0] cols;
   } lane_ctrl_type;

   function automatic logic fp_is_nan(input logic [63:0] v);
      return (v[62:52] == 11'h7ff) && (v[51:0] != 52'h0);
   endfunction

   function automatic logic fp_is_inf(input logic [63:0] v);
      return (v[62:52] == 11'h7ff) && (v[51:0] == 52'h0);
   endfunction

   function automatic logic fp_is_zero(input logic [63:0] v);
      return v[62:0] == 63'h0;
   endfunction

   // number of extra multiplies after x*x for a row factor code
   function automatic logic [2:0] factor_count(input logic [2:0] mode);
      logic [2:0] n;
      unique case (mode)
         MODE_W:    n = 3'd1;
         MODE_W2:   n = 3'd2;
         MODE_E2W2: n = 3'd4;
         MODE_E2W:  n = 3'd3;
         default:   n = 3'd0;
      endcase
      return n;
   endfunction

   // Round to nearest even and pack. exp >= 1; mant[52] set unless exp == 1.
   function automatic logic [63:0] round_pack(input logic sign,
                                              input logic signed [EXP_W-1:0] exp,
                                              input logic [52:0] mant,
                                              input logic guard,
                                              input logic sticky);
      logic [53:0]             mr;
      logic signed [EXP_W-1:0] e2;
      logic [63:0]             r;
      mr = {1'b0, mant} + 54'(guard && (sticky || mant[0]));
      e2 = exp;
      if (mr[53]) begin
         e2 = exp + 13'sd1;
         mr = mr >> 1;
      end
      if (e2 >= 13'sd2047) begin
         r = {sign, 11'h7ff, 52'h0};
      end else if (mr[52]) begin
         r = {sign, e2[10:0], mr[51:0]};
      end else begin
         r = {sign, 11'h0, mr[51:0]};
      end
      return r;
   endfunction

endpackage

// File: sv/wga_fmul.sv
// ----------------------------------------------------------------------------
// wga_fmul: multi-cycle double-precision multiplier
// 53x53 mantissa product built from four 27x27 partial products, then an
// iterative normalize and round-to-nearest-even.
// ----------------------------------------------------------------------------
module wga_fmul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] result
);
   import wga_pkg::*;

   localparam int PROD_W = 106;

   typedef enum logic [1:0] {M_IDLE, M_PROD, M_NORM} state_type;

   state_type               state_ff, state_in;
   logic                    done_ff, done_in;
   logic [63:0]             result_ff, result_in;
   logic                    sign_ff, sign_in;
   logic signed [EXP_W-1:0] exp_ff, exp_in;
   logic [52:0]             ma_ff, ma_in, mb_ff, mb_in;
   logic [PROD_W-1:0]       acc_ff, acc_in;
   logic [53:0]             pp_ff, pp_in;
   logic [2:0]              pcnt_ff, pcnt_in;

   logic [26:0]       op1, op2;
   logic [PROD_W-1:0] pp_ext;
   logic [10:0]       ea, eb;
   logic              sgn;

   always_comb begin
      unique case (pcnt_ff[1:0])
         2'd0: begin op1 = ma_ff[26:0];          op2 = mb_ff[26:0];          end
         2'd1: begin op1 = ma_ff[26:0];          op2 = {1'b0, mb_ff[52:27]}; end
         2'd2: begin op1 = {1'b0, ma_ff[52:27]}; op2 = mb_ff[26:0];          end
         default: begin op1 = {1'b0, ma_ff[52:27]}; op2 = {1'b0, mb_ff[52:27]}; end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      sign_in   = sign_ff;
      exp_in    = exp_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      acc_in    = acc_ff;
      pp_in     = 54'(op1) * 54'(op2);
      pcnt_in   = pcnt_ff;
      pp_ext    = {52'b0, pp_ff};
      ea        = (op_a[62:52] == 11'h0) ? 11'd1 : op_a[62:52];
      eb        = (op_b[62:52] == 11'h0) ? 11'd1 : op_b[62:52];
      sgn       = op_a[63] ^ op_b[63];

      unique case (state_ff)
         M_IDLE: begin
            if (start) begin
               if (fp_is_nan(op_a)) begin
                  result_in = op_a | QUIET_BIT;
                  done_in   = 1'b1;
               end else if (fp_is_nan(op_b)) begin
                  result_in = op_b | QUIET_BIT;
                  done_in   = 1'b1;
               end else if ((fp_is_inf(op_a) && fp_is_zero(op_b)) ||
                            (fp_is_zero(op_a) && fp_is_inf(op_b))) begin
                  result_in = DEFAULT_NAN;
                  done_in   = 1'b1;
               end else if (fp_is_inf(op_a) || fp_is_inf(op_b)) begin
                  result_in = {sgn, 11'h7ff, 52'h0};
                  done_in   = 1'b1;
               end else if (fp_is_zero(op_a) || fp_is_zero(op_b)) begin
                  result_in = {sgn, 63'h0};
                  done_in   = 1'b1;
               end else begin
                  sign_in  = sgn;
                  exp_in   = $signed(13'(ea)) + $signed(13'(eb)) - 13'sd1022;
                  ma_in    = {op_a[62:52] != 11'h0, op_a[51:0]};
                  mb_in    = {op_b[62:52] != 11'h0, op_b[51:0]};
                  acc_in   = '0;
                  pcnt_in  = 3'd0;
                  state_in = M_PROD;
               end
            end
         end
         M_PROD: begin
            // partial product i is formed at count i and summed at count i+1
            pcnt_in = pcnt_ff + 3'd1;
            if (pcnt_ff == 3'd1) begin
               acc_in = acc_ff + pp_ext;
            end else if (pcnt_ff == 3'd4) begin
               acc_in   = acc_ff + (pp_ext << 54);
               state_in = M_NORM;
            end else if (pcnt_ff != 3'd0) begin
               acc_in = acc_ff + (pp_ext << 27);
            end
         end
         default: begin
            if (exp_ff < -13'sd120) begin
               acc_in = {105'b0, |acc_ff};
               exp_in = 13'sd1;
            end else if (exp_ff < -13'sd6) begin
               acc_in = {8'b0, acc_ff[105:9], |acc_ff[8:0]};
               exp_in = exp_ff + 13'sd8;
            end else if (exp_ff < 13'sd1) begin
               acc_in = {1'b0, acc_ff[105:2], |acc_ff[1:0]};
               exp_in = exp_ff + 13'sd1;
            end else if (!acc_ff[105] && exp_ff > 13'sd8 && acc_ff[105:98] == 8'h0) begin
               acc_in = acc_ff << 8;
               exp_in = exp_ff - 13'sd8;
            end else if (!acc_ff[105] && exp_ff > 13'sd1) begin
               acc_in = acc_ff << 1;
               exp_in = exp_ff - 13'sd1;
            end else begin
               result_in = round_pack(sign_ff, exp_ff, acc_ff[105:53], acc_ff[52],
                                      |acc_ff[51:0]);
               done_in   = 1'b1;
               state_in  = M_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      result_ff <= result_in;
      sign_ff   <= sign_in;
      exp_ff    <= exp_in;
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      acc_ff    <= acc_in;
      pp_ff     <= pp_in;
      pcnt_ff   <= pcnt_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// File: sv/wga_fadd.sv
// ----------------------------------------------------------------------------
// wga_fadd: multi-cycle double-precision adder
// Swap by magnitude, align with guard/round/sticky, add or subtract,
// iterative normalize, round-to-nearest-even.
// ----------------------------------------------------------------------------
module wga_fadd (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] result
);
   import wga_pkg::*;

   localparam int EXT_W = 56;

   typedef enum logic [1:0] {A_IDLE, A_ALIGN, A_SUM, A_NORM} state_type;

   state_type         state_ff, state_in;
   logic              done_ff, done_in;
   logic [63:0]       result_ff, result_in;
   logic              sign_ff, sign_in;
   logic              sub_ff, sub_in;
   logic [11:0]       exp_ff, exp_in;
   logic [10:0]       dist_ff, dist_in;
   logic [52:0]       mbig_ff, mbig_in;
   logic [EXT_W-1:0]  msml_ff, msml_in;
   logic [EXT_W:0]    sum_ff, sum_in;

   logic [63:0]      big, sml;
   logic [10:0]      ebig, esml;
   logic [EXT_W-1:0] shifted, lost_mask;

   always_comb begin
      state_in  = state_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      sign_in   = sign_ff;
      sub_in    = sub_ff;
      exp_in    = exp_ff;
      dist_in   = dist_ff;
      mbig_in   = mbig_ff;
      msml_in   = msml_ff;
      sum_in    = sum_ff;

      if (op_b[62:0] > op_a[62:0]) begin
         big = op_b;
         sml = op_a;
      end else begin
         big = op_a;
         sml = op_b;
      end
      ebig      = (big[62:52] == 11'h0) ? 11'd1 : big[62:52];
      esml      = (sml[62:52] == 11'h0) ? 11'd1 : sml[62:52];
      shifted   = msml_ff >> dist_ff;
      lost_mask = (56'd1 << dist_ff) - 56'd1;

      unique case (state_ff)
         A_IDLE: begin
            if (start) begin
               if (fp_is_nan(op_a)) begin
                  result_in = op_a | QUIET_BIT;
                  done_in   = 1'b1;
               end else if (fp_is_nan(op_b)) begin
                  result_in = op_b | QUIET_BIT;
                  done_in   = 1'b1;
               end else if (fp_is_inf(op_a) && fp_is_inf(op_b) && (op_a[63] != op_b[63])) begin
                  result_in = DEFAULT_NAN;
                  done_in   = 1'b1;
               end else if (fp_is_inf(op_a)) begin
                  result_in = op_a;
                  done_in   = 1'b1;
               end else if (fp_is_inf(op_b)) begin
                  result_in = op_b;
                  done_in   = 1'b1;
               end else if (fp_is_zero(op_a) && fp_is_zero(op_b)) begin
                  result_in = {op_a[63] & op_b[63], 63'h0};
                  done_in   = 1'b1;
               end else if (fp_is_zero(op_a)) begin
                  result_in = op_b;
                  done_in   = 1'b1;
               end else if (fp_is_zero(op_b)) begin
                  result_in = op_a;
                  done_in   = 1'b1;
               end else begin
                  sign_in  = big[63];
                  sub_in   = op_a[63] ^ op_b[63];
                  exp_in   = {1'b0, ebig};
                  dist_in  = ebig - esml;
                  mbig_in  = {big[62:52] != 11'h0, big[51:0]};
                  msml_in  = {sml[62:52] != 11'h0, sml[51:0], 3'b000};
                  state_in = A_ALIGN;
               end
            end
         end
         A_ALIGN: begin
            if (dist_ff >= 11'd56) begin
               msml_in = {55'b0, 1'b1};
            end else begin
               msml_in = {shifted[EXT_W-1:1], shifted[0] | (|(msml_ff & lost_mask))};
            end
            state_in = A_SUM;
         end
         A_SUM: begin
            if (sub_ff) begin
               sum_in = {1'b0, mbig_ff, 3'b000} - {1'b0, msml_ff};
            end else begin
               sum_in = {1'b0, mbig_ff, 3'b000} + {1'b0, msml_ff};
            end
            state_in = A_NORM;
         end
         default: begin
            if (sum_ff == '0) begin
               result_in = 64'h0;   // exact cancellation gives +0
               done_in   = 1'b1;
               state_in  = A_IDLE;
            end else if (sum_ff[56]) begin
               sum_in = {1'b0, sum_ff[56:2], sum_ff[1] | sum_ff[0]};
               exp_in = exp_ff + 12'd1;
            end else if (!sum_ff[55] && exp_ff > 12'd8 && sum_ff[55:48] == 8'h0) begin
               sum_in = sum_ff << 8;
               exp_in = exp_ff - 12'd8;
            end else if (!sum_ff[55] && exp_ff > 12'd1) begin
               sum_in = sum_ff << 1;
               exp_in = exp_ff - 12'd1;
            end else begin
               result_in = round_pack(sign_ff, $signed({1'b0, exp_ff}), sum_ff[55:3],
                                      sum_ff[2], |sum_ff[1:0]);
               done_in   = 1'b1;
               state_in  = A_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      result_ff <= result_in;
      sign_ff   <= sign_in;
      sub_ff    <= sub_in;
      exp_ff    <= exp_in;
      dist_ff   <= dist_in;
      mbig_ff   <= mbig_in;
      msml_ff   <= msml_in;
      sum_ff    <= sum_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// File: sv/wga_lane.sv
// ----------------------------------------------------------------------------
// wga_lane: one column lane of the Gram accumulator
// Lane l owns the upper-triangle entries (j,l) for j <= l and vector entry l.
// It sequences its multiplier and adder over those entries for each row.
// ----------------------------------------------------------------------------
module wga_lane #(
   parameter int MAX_COLUMNS = wga_pkg::MAX_COLUMNS_DEF,
   parameter int LANE_INDEX  = 0,
   parameter int COL_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  wga_pkg::lane_ctrl_type ctrl,
   input  wga_pkg::row_type       row,
   input  logic [COL_W-1:0]       rd_idx,
   output logic                   busy,
   output logic [63:0]            rd_gram,
   output logic [63:0]            rd_vec
);
   import wga_pkg::*;

   typedef enum logic [2:0] {L_IDLE, L_MUL, L_MUL_WAIT, L_ADD, L_ADD_WAIT} state_type;

   state_type        state_ff, state_in;
   logic [COL_W-1:0] j_ff, j_in;
   logic             vec_ff, vec_in;
   logic [2:0]       step_ff, step_in;
   logic [63:0]      prod_ff, prod_in;
   logic [63:0]      acc_ff [MAX_COLUMNS];
   logic [63:0]      vacc_ff;

   logic        mul_start, mul_done, add_start, add_done;
   logic [63:0] mul_a, mul_b, mul_res, add_a, add_res;
   logic [2:0]  nsteps;
   logic [63:0] factor;

   always_comb begin
      nsteps = vec_ff ? {2'b00, ctrl.vec_weighted} : factor_count(ctrl.mode);
      // e terms come first in the e*e*w*w and e*e*w orders
      if (!vec_ff && (ctrl.mode == MODE_E2W2 || ctrl.mode == MODE_E2W) && step_ff <= 3'd2) begin
         factor = row.e;
      end else begin
         factor = row.w;
      end
      if (step_ff == 3'd0) begin
         mul_a = row.x[LANE_INDEX];
         mul_b = vec_ff ? row.y : row.x[XIDX_W'(j_ff)];
      end else begin
         mul_a = prod_ff;
         mul_b = factor;
      end
      add_a     = vec_ff ? vacc_ff : acc_ff[j_ff];
      mul_start = (state_ff == L_MUL);
      add_start = (state_ff == L_ADD);
   end

   always_comb begin
      state_in = state_ff;
      j_in     = j_ff;
      vec_in   = vec_ff;
      step_in  = step_ff;
      prod_in  = prod_ff;
      unique case (state_ff)
         L_IDLE: begin
            if (ctrl.start && 4'(LANE_INDEX) < ctrl.cols) begin
               j_in     = '0;
               vec_in   = 1'b0;
               step_in  = 3'd0;
               state_in = L_MUL;
            end
         end
         L_MUL:      state_in = L_MUL_WAIT;
         L_MUL_WAIT: begin
            if (mul_done) begin
               prod_in = mul_res;
               if (step_ff < nsteps) begin
                  step_in  = step_ff + 3'd1;
                  state_in = L_MUL;
               end else begin
                  state_in = L_ADD;
               end
            end
         end
         L_ADD:      state_in = L_ADD_WAIT;
         default: begin
            if (add_done) begin
               step_in = 3'd0;
               if (vec_ff) begin
                  state_in = L_IDLE;
               end else if (j_ff == COL_W'(LANE_INDEX)) begin
                  vec_in   = 1'b1;
                  state_in = L_MUL;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = L_MUL;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         for (int i = 0; i < MAX_COLUMNS; i++) acc_ff[i] <= 64'h0;
         vacc_ff  <= 64'h0;
      end else begin
         state_ff <= state_in;
         if (ctrl.clear) begin
            for (int i = 0; i < MAX_COLUMNS; i++) acc_ff[i] <= 64'h0;
            vacc_ff <= 64'h0;
         end else if (state_ff == L_ADD_WAIT && add_done) begin
            if (vec_ff) vacc_ff <= add_res;
            else        acc_ff[j_ff] <= add_res;
         end
      end
      j_ff    <= j_in;
      vec_ff  <= vec_in;
      step_ff <= step_in;
      prod_ff <= prod_in;
   end

   wga_fmul u_fmul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   wga_fadd u_fadd (
      .clock  (clock),
      .reset  (reset),
      .start  (add_start),
      .op_a   (add_a),
      .op_b   (prod_ff),
      .done   (add_done),
      .result (add_res)
   );

   assign busy    = (state_ff != L_IDLE);
   assign rd_gram = acc_ff[rd_idx];
   assign rd_vec  = vacc_ff;

endmodule

// File: sv/weighted_gram_accumulator.sv
// ----------------------------------------------------------------------------
// weighted_gram_accumulator: X'DX upper triangle and X'y in double precision
// One lane per regressor column accumulates its column of the triangle and
// its vector entry; a readout stage merges the lanes on the last row.
// ----------------------------------------------------------------------------
//   channel   ports   direction   carries
//   request   req_*   in          one regressor row with y, w, e, last_row
//   response  rsp_*   out         one accumulated entry per item
//   config    csr_*   in/out      weight_mode, vector_weighted, active_columns
//
// One row at a time. Lane K-1 is the longest: K entries of (1+f) multiplies
// and one add, f = 0..4 set by weight_mode, plus the vector entry with 1+v
// multiplies and one add, v = vector_weighted. Subnormal operands and
// underflow make a row take longer.
// Readout of the last row gives K*(K+1)/2+K items, one a cycle unless stalled.
// Synchronous reset zeroes all sums at once; a stalled output holds its item.
// ----------------------------------------------------------------------------
module weighted_gram_accumulator #(
   parameter int MAX_COLUMNS = wga_pkg::MAX_COLUMNS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [63:0]                     req_x_col0,
   input  logic [63:0]                     req_x_col1,
   input  logic [63:0]                     req_x_col2,
   input  logic [63:0]                     req_x_col3,
   input  logic [63:0]                     req_x_col4,
   input  logic [63:0]                     req_x_col5,
   input  logic [63:0]                     req_x_col6,
   input  logic [63:0]                     req_x_col7,
   input  logic [63:0]                     req_response,
   input  logic [63:0]                     req_weight,
   input  logic [63:0]                     req_residual,
   input  logic                            req_last_row,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [63:0]                     rsp_value,
   output logic [2:0]                      rsp_row_pos,
   output logic [2:0]                      rsp_col_pos,
   output logic                            rsp_is_vector,
   output logic                            rsp_last,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [wga_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [wga_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [wga_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import wga_pkg::*;

   localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

   typedef enum logic [1:0] {T_IDLE, T_START, T_RUN, T_READ} state_type;

   state_type        state_ff, state_in;
   logic [2:0]       weight_mode_ff;
   logic             vector_weighted_ff;
   logic [3:0]       active_columns_ff;
   row_type          row_ff;
   logic             last_row_ff, last_row_in;
   logic [COL_W-1:0] rj_ff, rj_in, rl_ff, rl_in;
   logic             rvec_ff, rvec_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [63:0]      value_ff, value_in;
   logic [2:0]       out_row_ff, out_row_in, out_col_ff, out_col_in;
   logic             out_vec_ff, out_vec_in, out_last_ff, out_last_in;

   lane_ctrl_type          ctrl;
   logic [3:0]             cols;
   logic [COL_W-1:0]       last_col;
   logic [MAX_COLUMNS-1:0] busy;
   logic [63:0]            gram_rd [MAX_COLUMNS];
   logic [63:0]            vec_rd  [MAX_COLUMNS];
   logic                   csr_wr, accept, final_item;

   assign csr_wr = csr_psel & csr_penable & csr_pwrite;
   assign accept = req_valid & ~req_stall;

   always_comb begin
      if (active_columns_ff == 4'd0) begin
         cols = 4'd1;
      end else if (active_columns_ff > 4'(MAX_COLUMNS)) begin
         cols = 4'(MAX_COLUMNS);
      end else begin
         cols = active_columns_ff;
      end
      last_col = COL_W'(cols - 4'd1);
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_WEIGHT_MODE:     csr_prdata = {29'b0, weight_mode_ff};
         REG_VECTOR_WEIGHTED: csr_prdata = {31'b0, vector_weighted_ff};
         REG_ACTIVE_COLUMNS:  csr_prdata = {28'b0, active_columns_ff};
         default:             csr_prdata = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      last_row_in  = last_row_ff;
      rj_in        = rj_ff;
      rl_in        = rl_ff;
      rvec_in      = rvec_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      value_in     = value_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_vec_in   = out_vec_ff;
      out_last_in  = out_last_ff;
      final_item   = rvec_ff && (rj_ff == last_col);

      ctrl.start        = 1'b0;
      ctrl.clear        = 1'b0;
      ctrl.mode         = weight_mode_ff;
      ctrl.vec_weighted = vector_weighted_ff;
      ctrl.cols         = cols;

      unique case (state_ff)
         T_IDLE: begin
            if (req_valid) begin
               last_row_in = req_last_row;
               state_in    = T_START;
            end
         end
         T_START: begin
            ctrl.start = 1'b1;
            state_in   = T_RUN;
         end
         T_RUN: begin
            if (busy == '0) begin
               rj_in    = '0;
               rl_in    = '0;
               rvec_in  = 1'b0;
               state_in = last_row_ff ? T_READ : T_IDLE;
            end
         end
         default: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               value_in     = rvec_ff ? vec_rd[rj_ff] : gram_rd[rl_ff];
               out_row_in   = 3'(rj_ff);
               out_col_in   = rvec_ff ? 3'd0 : 3'(rl_ff);
               out_vec_in   = rvec_ff;
               out_last_in  = final_item;
               if (final_item) begin
                  ctrl.clear = 1'b1;
                  state_in   = T_IDLE;
               end else if (rvec_ff) begin
                  rj_in = rj_ff + 1'b1;
               end else if (rl_ff == last_col) begin
                  // triangle row done: next row starts on the diagonal
                  if (rj_ff == last_col) begin
                     rvec_in = 1'b1;
                     rj_in   = '0;
                  end else begin
                     rj_in = rj_ff + 1'b1;
                     rl_in = rj_ff + 1'b1;
                  end
               end else begin
                  rl_in = rl_ff + 1'b1;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= T_IDLE;
         rsp_valid_ff       <= 1'b0;
         weight_mode_ff     <= MODE_ONE;
         vector_weighted_ff <= 1'b0;
         active_columns_ff  <= ACTIVE_COLUMNS_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr) begin
            unique case (csr_paddr[3:2])
               REG_WEIGHT_MODE:     weight_mode_ff     <= csr_pwdata[2:0];
               REG_VECTOR_WEIGHTED: vector_weighted_ff <= csr_pwdata[0];
               REG_ACTIVE_COLUMNS:  active_columns_ff  <= csr_pwdata[3:0];
               default: ;
            endcase
         end
      end
      if (accept) begin
         row_ff.x[0] <= req_x_col0;
         row_ff.x[1] <= req_x_col1;
         row_ff.x[2] <= req_x_col2;
         row_ff.x[3] <= req_x_col3;
         row_ff.x[4] <= req_x_col4;
         row_ff.x[5] <= req_x_col5;
         row_ff.x[6] <= req_x_col6;
         row_ff.x[7] <= req_x_col7;
         row_ff.y    <= req_response;
         row_ff.w    <= req_weight;
         row_ff.e    <= req_residual;
      end
      last_row_ff <= last_row_in;
      rj_ff       <= rj_in;
      rl_ff       <= rl_in;
      rvec_ff     <= rvec_in;
      value_ff    <= value_in;
      out_row_ff  <= out_row_in;
      out_col_ff  <= out_col_in;
      out_vec_ff  <= out_vec_in;
      out_last_ff <= out_last_in;
   end

   for (genvar g = 0; g < MAX_COLUMNS; g++) begin : g_lane
      wga_lane #(
         .MAX_COLUMNS (MAX_COLUMNS),
         .LANE_INDEX  (g),
         .COL_W       (COL_W)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .row     (row_ff),
         .rd_idx  (rj_ff),
         .busy    (busy[g]),
         .rd_gram (gram_rd[g]),
         .rd_vec  (vec_rd[g])
      );
   end

   assign req_stall     = (state_ff != T_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = value_ff;
   assign rsp_row_pos   = out_row_ff;
   assign rsp_col_pos   = out_col_ff;
   assign rsp_is_vector = out_vec_ff;
   assign rsp_last      = out_last_ff;
   assign csr_pready    = 1'b1;

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for weighted_gram_accumulator
// Sends regressor rows under each weight mode, vector weighting and column
// count, and checks every triangle and vector entry of each readout run
// against a double-precision accumulator kept in the bench.
// ----------------------------------------------------------------------------
module tb;
   import wga_pkg::*;

   localparam int  LIMIT   = 4000000;
   localparam int  N_ROWS  = 210;

   typedef struct {
      logic [63:0] value;
      logic [2:0]  row_pos;
      logic [2:0]  col_pos;
      logic        is_vector;
      logic        last;
   } entry_type;

   class gram_scoreboard;
      real         gram[36];
      real         vec[8];
      logic [2:0]  mode;
      logic        vec_weighted;
      logic [3:0]  cols;
      entry_type   pending[$];
      int          errors;
      int          checked;

      function new();
         foreach (gram[i]) gram[i] = 0.0;
         foreach (vec[i]) vec[i] = 0.0;
         mode = MODE_ONE;
         vec_weighted = 1'b0;
         cols = ACTIVE_COLUMNS_RESET;
      endfunction

      function int cols_used();
         if (cols == 0) return 1;
         if (cols > 8) return 8;
         return cols;
      endfunction

      function int slot(int j, int l);
         return j * 8 - (j * (j - 1)) / 2 + (l - j);
      endfunction

      function void note_row(row_type r, logic last_row);
         real x[8];
         real y, w, e, p;
         int k, n, total;
         entry_type t;
         k = cols_used();
         y = $bitstoreal(r.y);
         w = $bitstoreal(r.w);
         e = $bitstoreal(r.e);
         for (int j = 0; j < 8; j++) x[j] = $bitstoreal(r.x[j]);
         for (int j = 0; j < k; j++) begin
            for (int l = j; l < k; l++) begin
               p = x[l] * x[j];
               case (mode)
                  MODE_W:    p = p * w;
                  MODE_W2:   begin p = p * w; p = p * w; end
                  MODE_E2W2: begin p = p * e; p = p * e; p = p * w; p = p * w; end
                  MODE_E2W:  begin p = p * e; p = p * e; p = p * w; end
                  default:   ;
               endcase
               gram[slot(j, l)] = gram[slot(j, l)] + p;
            end
         end
         for (int j = 0; j < k; j++) begin
            p = x[j] * y;
            if (vec_weighted) p = p * w;
            vec[j] = vec[j] + p;
         end
         if (!last_row) return;
         total = k * (k + 1) / 2 + k;
         n = 0;
         for (int j = 0; j < k; j++) begin
            for (int l = j; l < k; l++) begin
               n++;
               t.value = $realtobits(gram[slot(j, l)]);
               t.row_pos = 3'(j);
               t.col_pos = 3'(l);
               t.is_vector = 1'b0;
               t.last = (n == total);
               pending.push_back(t);
            end
         end
         for (int j = 0; j < k; j++) begin
            n++;
            t.value = $realtobits(vec[j]);
            t.row_pos = 3'(j);
            t.col_pos = 3'd0;
            t.is_vector = 1'b1;
            t.last = (n == total);
            pending.push_back(t);
         end
         foreach (gram[i]) gram[i] = 0.0;
         foreach (vec[i]) vec[i] = 0.0;
      endfunction

      function void check_entry(entry_type got);
         entry_type want;
         logic value_ok;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected result value=%h row=%0d col=%0d vec=%0b last=%0b",
                     $time, got.value, got.row_pos, got.col_pos, got.is_vector, got.last);
            return;
         end
         want = pending.pop_front();
         // NaN payloads are not pinned down; any NaN matches an expected NaN
         if (fp_is_nan(want.value)) value_ok = fp_is_nan(got.value);
         else value_ok = (want.value === got.value);
         if (!value_ok || want.row_pos !== got.row_pos || want.col_pos !== got.col_pos
             || want.is_vector !== got.is_vector || want.last !== got.last) begin
            errors++;
            $display("%0t: mismatch expected value=%h row=%0d col=%0d vec=%0b last=%0b",
                     $time, want.value, want.row_pos, want.col_pos, want.is_vector,
                     want.last);
            $display("%0t:          actual   value=%h row=%0d col=%0d vec=%0b last=%0b",
                     $time, got.value, got.row_pos, got.col_pos, got.is_vector, got.last);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_x_col0, req_x_col1, req_x_col2, req_x_col3;
   logic [63:0] req_x_col4, req_x_col5, req_x_col6, req_x_col7;
   logic [63:0] req_response, req_weight, req_residual;
   logic        req_last_row;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_value;
   logic [2:0]  rsp_row_pos, rsp_col_pos;
   logic        rsp_is_vector, rsp_last;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic        csr_pready;

   gram_scoreboard sb;
   int          cycles;
   int          rows_sent;
   int          runs_done;
   bit          calm;        // no idling on either side while set
   bit          took;
   int          hold;

   weighted_gram_accumulator uut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, sb.pending.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      entry_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.value = rsp_value;
         got.row_pos = rsp_row_pos;
         got.col_pos = rsp_col_pos;
         got.is_vector = rsp_is_vector;
         got.last = rsp_last;
         sb.check_entry(got);
         took = 1'b1;
      end
   end

   // receiver stall: a random hold after each accepted result
   always @(negedge clock) begin
      if (took) begin
         took = 1'b0;
         hold = calm ? 0 : $urandom_range(0, 3);
      end
      if (hold > 0) begin
         rsp_stall <= 1'b1;
         hold--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [63:0] rand_double(int special_pct);
      logic [63:0] raw;
      logic        s;
      logic [51:0] m;
      raw = {$urandom, $urandom};
      s = raw[63];
      m = 52'({$urandom, $urandom});
      if ($urandom_range(0, 99) < special_pct) begin
         case ($urandom_range(0, 6))
            0: return {s, 63'h0};
            1: return {s, 11'h7ff, 52'h0};
            2: return {s, 11'h7ff, m | 52'h1};
            3: return {s, 11'h0, m};
            4: return {s, 11'h7fe, m};
            5: return {s, 11'h001, m};
            default: return raw;
         endcase
      end
      return {s, 11'(1013 + $urandom_range(0, 20)), m};
   endfunction

   task automatic write_reg(logic [1:0] idx, logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_WEIGHT_MODE:     sb.mode = data[2:0];
         REG_VECTOR_WEIGHTED: sb.vec_weighted = data[0];
         default:             sb.cols = data[3:0];
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // block must be idle: all results in and the last row fully processed
   task automatic drain();
      while (sb.pending.size() > 0 || req_stall) @(negedge clock);
   endtask

   task automatic send_row(int special_pct, logic last_row);
      row_type r;
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      for (int j = 0; j < NUM_X; j++) r.x[j] = rand_double(special_pct);
      r.y = rand_double(special_pct);
      r.w = rand_double(special_pct);
      r.e = rand_double(special_pct);
      req_x_col0 <= r.x[0];
      req_x_col1 <= r.x[1];
      req_x_col2 <= r.x[2];
      req_x_col3 <= r.x[3];
      req_x_col4 <= r.x[4];
      req_x_col5 <= r.x[5];
      req_x_col6 <= r.x[6];
      req_x_col7 <= r.x[7];
      req_response <= r.y;
      req_weight   <= r.w;
      req_residual <= r.e;
      req_last_row <= last_row;
      req_valid    <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_row(r, last_row);
      rows_sent++;
      if (last_row) runs_done++;
      @(negedge clock);
   endtask

   task automatic run_set(logic [2:0] mode, logic vw, logic [3:0] cols, int n_rows,
                          int special_pct);
      req_valid <= 1'b0;
      drain();
      write_reg(REG_WEIGHT_MODE, 32'(mode));
      write_reg(REG_VECTOR_WEIGHTED, 32'(vw));
      write_reg(REG_ACTIVE_COLUMNS, 32'(cols));
      calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n_rows; i++) send_row(special_pct, i == n_rows - 1);
   endtask

   initial begin
      logic [3:0] dir_cols[8] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd9, 4'd5};
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_last_row = 1'b0;
      {req_x_col0, req_x_col1, req_x_col2, req_x_col3} = '0;
      {req_x_col4, req_x_col5, req_x_col6, req_x_col7} = '0;
      {req_response, req_weight, req_residual} = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      rows_sent = 0;
      runs_done = 0;
      calm = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default registers after reset
      send_row(30, 1'b0);
      send_row(30, 1'b1);
      // every mode code, unknown ones too, with extreme column counts
      for (int m = 0; m < 8; m++) run_set(3'(m), 1'(m % 2), dir_cols[m], 2, 40);
      // column count changed between rows of one run
      run_set(MODE_W, 1'b1, 4'd3, 1, 10);
      req_valid <= 1'b0;
      drain();
      write_reg(REG_ACTIVE_COLUMNS, 32'd6);
      send_row(10, 1'b0);
      req_valid <= 1'b0;
      drain();
      write_reg(REG_ACTIVE_COLUMNS, 32'd2);
      send_row(10, 1'b1);

      while (rows_sent < N_ROWS)
         run_set(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                 ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(1, 8)),
                 $urandom_range(1, 6), 8);
      req_valid <= 1'b0;
      drain();

      $display("Sent %0d rows in %0d readout runs; %0d entries checked over all modes",
               rows_sent, runs_done, sb.checked);
      $display("and column counts, with special values and random idling on both sides.");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d errors, %0d results never came", sb.errors, sb.pending.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
